// ----- design/ffha_pkg.sv -----
// Shared types, sizes and status codes for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;
   localparam int HeapWords  = 65536;
   localparam int MaxChunks  = 1024;
   localparam int WordBytes  = 8;
   localparam int IdxW       = $clog2(MaxChunks);
   localparam int CntW       = IdxW + 1;
   localparam int AddrW      = 16;
   localparam int LenW       = 17;
   localparam int BytesW     = 20;
   localparam int ShiftW     = $clog2(WordBytes);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_ZERO    = 3'd1;
   localparam logic [2:0] ST_NOFIT   = 3'd2;
   localparam logic [2:0] ST_UNKNOWN = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   typedef struct packed {
      logic              kind;
      logic [BytesW-1:0] request_bytes;
      logic [AddrW-1:0]  release_word;
      logic              release_present;
   } req_type;

   typedef struct packed {
      logic [AddrW-1:0] granted_word;
      logic [2:0]       status;
   } rsp_type;

   // One list entry: start word and length in words.
   typedef struct packed {
      logic [AddrW-1:0] start;
      logic [LenW-1:0]  length;
   } chunk_type;
endpackage
`default_nettype wire

// ----- design/ffha_ram.sv -----
// Single-port-write, single-port-read chunk memory with registered read data.
`default_nettype none
module ffha_ram
   import ffha_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire logic [IdxW-1:0] wr_addr,
   input  wire chunk_type wr_data,
   input  wire logic [IdxW-1:0] rd_addr,
   output chunk_type      rd_data
);
   chunk_type mem [MaxChunks];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- design/first_fit_heap_allocator_top.sv -----
// Top level of the first-fit heap allocator: list sequencer and its two memories.
//
//  channel | direction | handshake        | payload
//  req     | in        | start & !busy    | req_data (req_type)
//  rsp     | out       | rsp_valid strobe | rsp_data (rsp_type)
//
// Each pass over a list reads its entries one at a time, because every memory
// read has a registered output and one read port serves each list. An allocate
// walks the free list to coalesce, again to search, then shifts entries to drop,
// insert the used entry and insert the remainder; a free searches, coalesces
// when the free list is full, and shifts. Reset is synchronous: it sets the
// free count to one, clears the used count and sends the sequencer to an init
// state that writes free list entry zero. The receiver cannot stall: each
// result is shown for exactly one cycle on rsp_valid.
`default_nettype none
module first_fit_heap_allocator_top
   import ffha_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   typedef enum logic [15:0] {
      S_INIT   = 16'h0001,
      S_IDLE   = 16'h0002,
      S_CO_RD  = 16'h0004,  // coalesce: issue read of entry i
      S_CO_WT  = 16'h0008,  // coalesce: data arrives, merge or push
      S_SR_RD  = 16'h0010,  // search list for fit or address
      S_SR_WT  = 16'h0020,
      S_DR_RD  = 16'h0040,  // drop: read i+1
      S_DR_WT  = 16'h0080,  // drop: write to i
      S_IN_RD  = 16'h0100,  // insert: read i-1
      S_IN_WT  = 16'h0200,  // insert: compare and shift up
      S_F_CO   = 16'h0400,  // free: decide coalesce before insert
      S_RESP   = 16'h0800,
      S_F_RD   = 16'h1000,  // free: coalesce, issue read of free entry i
      S_F_WT   = 16'h2000,
      S_A_TAIL = 16'h4000,
      S_F_DROP = 16'h8000
   } state_type;

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [CntW-1:0] fcnt_ff, fcnt_in, ucnt_ff, ucnt_in;
   logic [CntW-1:0] i_ff, i_in, top_ff, top_in;
   chunk_type       acc_ff, acc_in;       // coalesce top entry / found chunk
   chunk_type       ins_ff, ins_in;       // entry being inserted
   logic            ins_used_ff, ins_used_in; // insert target list
   logic            drop_used_ff, drop_used_in;
   logic [LenW-1:0] words_ff, words_in;
   rsp_type         rsp_ff, rsp_in;
   logic            tail_ff, tail_in;     // remainder insert pending
   chunk_type       tailc_ff, tailc_in;

   logic            f_we, u_we;
   logic [IdxW-1:0] f_wa, u_wa, f_ra, u_ra;
   chunk_type       f_wd, u_wd, f_rd, u_rd;

   ffha_ram u_free (.clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
                    .rd_addr(f_ra), .rd_data(f_rd));
   ffha_ram u_used (.clock, .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
                    .rd_addr(u_ra), .rd_data(u_rd));

   logic [LenW:0]     words_wide;
   logic [LenW-1:0]   req_words;
   logic [CntW-1:0]   i_m1, i_p1;
   chunk_type         lrd;          // read data of the list in use
   logic [AddrW:0]    acc_end;

   always_comb begin
      // The rounded word count can reach 2^17 for the largest byte counts. It
      // is clamped to the largest length, which still exceeds the heap size
      // and so never fits, but stays nonzero.
      words_wide = (LenW+1)'(({1'b0, req_data.request_bytes}
                              + (BytesW+1)'(WordBytes - 1)) >> ShiftW);
      req_words = words_wide[LenW] ? '1 : words_wide[LenW-1:0];
      i_m1    = i_ff - 1'b1;
      i_p1    = i_ff + 1'b1;
      acc_end = {1'b0, acc_ff.start} + acc_ff.length;
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      fcnt_in      = fcnt_ff;
      ucnt_in      = ucnt_ff;
      i_in         = i_ff;
      top_in       = top_ff;
      acc_in       = acc_ff;
      ins_in       = ins_ff;
      ins_used_in  = ins_used_ff;
      drop_used_in = drop_used_ff;
      words_in     = words_ff;
      rsp_in       = rsp_ff;
      tail_in      = tail_ff;
      tailc_in     = tailc_ff;
      f_we = 1'b0; u_we = 1'b0;
      f_wa = i_ff[IdxW-1:0]; u_wa = i_ff[IdxW-1:0];
      f_wd = acc_ff; u_wd = acc_ff;
      f_ra = i_ff[IdxW-1:0]; u_ra = i_ff[IdxW-1:0];
      lrd  = ins_used_ff ? u_rd : f_rd;
      unique case (state_ff)
         S_INIT: begin
            f_we = 1'b1; f_wa = '0;
            f_wd = '{start: '0, length: LenW'(HeapWords)};
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               words_in = req_words;
               rsp_in   = '{granted_word: '0, status: ST_OK};
               tail_in  = 1'b0;
               if (req_data.kind == 1'b0) begin
                  if (req_words == '0) begin
                     rsp_in.status = ST_ZERO;
                     state_in = S_RESP;
                  end else begin
                     i_in = '0; top_in = '0;
                     state_in = S_CO_RD;
                  end
               end else if (!req_data.release_present) begin
                  state_in = S_RESP;
               end else begin
                  i_in = '0;
                  state_in = S_SR_RD;
               end
            end
         end
         S_CO_RD: begin
            // fcnt >= 1 always when coalescing is reached with entries
            if (i_ff == fcnt_ff) begin
               if (fcnt_ff != '0) begin
                  f_we = 1'b1; f_wa = top_ff[IdxW-1:0]; f_wd = acc_ff;
                  fcnt_in = top_ff + 1'b1;
               end
               i_in = '0;
               state_in = S_SR_RD;
            end else begin
               state_in = S_CO_WT;
            end
         end
         S_CO_WT: begin
            if (i_ff == '0) begin
               acc_in = f_rd;
            end else if (acc_end == {1'b0, f_rd.start}) begin
               acc_in.length = acc_ff.length + f_rd.length;
            end else begin
               f_we = 1'b1; f_wa = top_ff[IdxW-1:0]; f_wd = acc_ff;
               top_in = top_ff + 1'b1;
               acc_in = f_rd;
            end
            i_in = i_p1;
            state_in = S_CO_RD;
         end
         S_SR_RD: begin
            u_ra = i_ff[IdxW-1:0];
            if (req_ff.kind == 1'b0 ? (i_ff == fcnt_ff) : (i_ff == ucnt_ff)) begin
               rsp_in.status = req_ff.kind ? ST_UNKNOWN : ST_NOFIT;
               state_in = S_RESP;
            end else begin
               state_in = S_SR_WT;
            end
         end
         S_SR_WT: begin
            if (req_ff.kind == 1'b0) begin
               if (f_rd.length >= words_ff) begin
                  if (ucnt_ff >= CntW'(MaxChunks)) begin
                     rsp_in.status = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     rsp_in.granted_word = f_rd.start;
                     tail_in  = (f_rd.length != words_ff);
                     tailc_in = '{start: f_rd.start + AddrW'(words_ff),
                                  length: f_rd.length - words_ff};
                     ins_in   = '{start: f_rd.start, length: words_ff};
                     drop_used_in = 1'b0;
                     state_in = S_DR_RD;
                  end
               end else begin
                  i_in = i_p1; state_in = S_SR_RD;
               end
            end else begin
               if (u_rd.start == req_ff.release_word) begin
                  acc_in = u_rd;
                  state_in = S_F_CO;
               end else begin
                  i_in = i_p1; state_in = S_SR_RD;
               end
            end
         end
         S_F_CO: begin
            // Found at i; coalesce only if the free list is full.
            ins_in = acc_ff;
            if (fcnt_ff >= CntW'(MaxChunks)) begin
               top_in = '0; words_in = LenW'(i_ff);  // remember used index
               i_in = '0;
               state_in = S_F_RD;
            end else begin
               words_in = LenW'(i_ff);
               state_in = S_F_DROP;
            end
         end
         S_F_RD: begin
            // Coalesce loop for the free path, reusing acc.
            if (i_ff == fcnt_ff) begin
               f_we = 1'b1; f_wa = top_ff[IdxW-1:0]; f_wd = acc_ff;
               fcnt_in = top_ff + 1'b1;
               state_in = S_F_DROP;
               if (top_ff + 1'b1 >= CntW'(MaxChunks)) begin
                  rsp_in.status = ST_FULL;
                  state_in = S_RESP;
               end
            end else begin
               state_in = S_F_WT;
            end
         end
         S_F_WT: begin
            if (i_ff == '0) begin
               acc_in = f_rd;
            end else if (acc_end == {1'b0, f_rd.start}) begin
               acc_in.length = acc_ff.length + f_rd.length;
            end else begin
               f_we = 1'b1; f_wa = top_ff[IdxW-1:0]; f_wd = acc_ff;
               top_in = top_ff + 1'b1;
               acc_in = f_rd;
            end
            i_in = i_p1;
            state_in = S_F_RD;
         end
         S_F_DROP: begin
            // Drop used entry, then insert ins into the free list.
            i_in = CntW'(words_ff);
            drop_used_in = 1'b1;
            state_in = S_DR_RD;
         end
         S_DR_RD: begin
            f_ra = i_p1[IdxW-1:0]; u_ra = i_p1[IdxW-1:0];
            if (i_p1 >= (drop_used_ff ? ucnt_ff : fcnt_ff)) begin
               if (drop_used_ff) begin
                  ucnt_in = ucnt_ff - 1'b1;
                  ins_used_in = 1'b0;
                  i_in = fcnt_ff;
               end else begin
                  fcnt_in = fcnt_ff - 1'b1;
                  ins_used_in = 1'b1;
                  i_in = ucnt_ff;
               end
               state_in = S_IN_RD;
            end else begin
               state_in = S_DR_WT;
            end
         end
         S_DR_WT: begin
            if (drop_used_ff) begin
               u_we = 1'b1; u_wd = u_rd;
            end else begin
               f_we = 1'b1; f_wd = f_rd;
            end
            i_in = i_p1;
            state_in = S_DR_RD;
         end
         S_IN_RD: begin
            f_ra = i_m1[IdxW-1:0]; u_ra = i_m1[IdxW-1:0];
            if (i_ff == '0) begin
               if (ins_used_ff) begin
                  u_we = 1'b1; u_wd = ins_ff; ucnt_in = ucnt_ff + 1'b1;
               end else begin
                  f_we = 1'b1; f_wd = ins_ff; fcnt_in = fcnt_ff + 1'b1;
               end
               state_in = S_A_TAIL;
            end else begin
               state_in = S_IN_WT;
            end
         end
         S_IN_WT: begin
            if (lrd.start > ins_ff.start) begin
               if (ins_used_ff) begin
                  u_we = 1'b1; u_wd = u_rd;
               end else begin
                  f_we = 1'b1; f_wd = f_rd;
               end
               i_in = i_m1;
               state_in = S_IN_RD;
            end else begin
               if (ins_used_ff) begin
                  u_we = 1'b1; u_wd = ins_ff; ucnt_in = ucnt_ff + 1'b1;
               end else begin
                  f_we = 1'b1; f_wd = ins_ff; fcnt_in = fcnt_ff + 1'b1;
               end
               state_in = S_A_TAIL;
            end
         end
         S_A_TAIL: begin
            if (tail_ff) begin
               tail_in = 1'b0;
               ins_in = tailc_ff;
               ins_used_in = 1'b0;
               i_in = fcnt_ff;
               state_in = S_IN_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         fcnt_ff  <= CntW'(1);
         ucnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         ucnt_ff  <= ucnt_in;
      end
      req_ff       <= req_in;
      i_ff         <= i_in;
      top_ff       <= top_in;
      acc_ff       <= acc_in;
      ins_ff       <= ins_in;
      ins_used_ff  <= ins_used_in;
      drop_used_ff <= drop_used_in;
      words_ff     <= words_in;
      rsp_ff       <= rsp_in;
      tail_ff      <= tail_in;
      tailc_ff     <= tailc_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   // Counts never exceed the list capacity.
   a_fcnt: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= CntW'(MaxChunks)) else $error("free count overflow");
   a_ucnt: assert property (@(posedge clock) disable iff (reset)
      ucnt_ff <= CntW'(MaxChunks)) else $error("used count overflow");
   // A response is followed by idle.
   a_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("response not followed by idle");
   // A refused request never carries a granted word.
   a_gnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |-> rsp_data.granted_word == '0)
      else $error("granted word on refusal");
endmodule
`default_nettype wire

// ----- tb/tb_first_fit_heap_allocator_top.sv -----
// Self-checking testbench for the first-fit heap allocator: random and directed requests.
`default_nettype none
module tb_first_fit_heap_allocator_top;
   import ffha_pkg::*;

   // Tracks the heap lists and holds the answers the allocator owes.
   class heap_ledger;
      int unsigned free_at[$];
      int unsigned free_len[$];
      int unsigned used_at[$];
      int unsigned used_len[$];
      rsp_type owed[$];
      int errors;

      function void clear();
         free_at = '{0};
         free_len = '{HeapWords};
         used_at.delete();
         used_len.delete();
         owed.delete();
         errors = 0;
      endfunction

      function void merge_free();
         int unsigned na[$];
         int unsigned nl[$];
         if (free_at.size() == 0) return;
         na.push_back(free_at[0]);
         nl.push_back(free_len[0]);
         for (int i = 1; i < free_at.size(); i++) begin
            if (na[na.size()-1] + nl[nl.size()-1] == free_at[i]) begin
               nl[nl.size()-1] += free_len[i];
            end else begin
               na.push_back(free_at[i]);
               nl.push_back(free_len[i]);
            end
         end
         free_at = na;
         free_len = nl;
      endfunction

      function void put_sorted(ref int unsigned at[$], ref int unsigned ln[$],
                               input int unsigned s, input int unsigned n);
         int k;
         k = at.size();
         while (k > 0 && at[k-1] > s) k--;
         at.insert(k, s);
         ln.insert(k, n);
      endfunction

      function void note_request(req_type r);
         rsp_type a;
         int unsigned words;
         int idx;
         a.granted_word = '0;
         a.status = ST_OK;
         if (r.kind == 1'b0) begin
            words = (int'(r.request_bytes) + WordBytes - 1) / WordBytes;
            if (words == 0) begin
               a.status = ST_ZERO;
            end else begin
               merge_free();
               idx = -1;
               foreach (free_at[i]) if (idx < 0 && free_len[i] >= words) idx = i;
               if (idx < 0) a.status = ST_NOFIT;
               else if (used_at.size() >= MaxChunks) a.status = ST_FULL;
               else begin
                  int unsigned s, tail;
                  s = free_at[idx];
                  tail = free_len[idx] - words;
                  free_at.delete(idx);
                  free_len.delete(idx);
                  put_sorted(used_at, used_len, s, words);
                  if (tail > 0) put_sorted(free_at, free_len, s + words, tail);
                  a.granted_word = s[AddrW-1:0];
               end
            end
         end else if (r.release_present) begin
            idx = -1;
            foreach (used_at[i]) if (idx < 0 && used_at[i] == r.release_word) idx = i;
            if (idx < 0) a.status = ST_UNKNOWN;
            else begin
               if (free_at.size() >= MaxChunks) merge_free();
               if (free_at.size() >= MaxChunks) a.status = ST_FULL;
               else begin
                  put_sorted(free_at, free_len, used_at[idx], used_len[idx]);
                  used_at.delete(idx);
                  used_len.delete(idx);
               end
            end
         end
         owed.push_back(a);
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            $display("%0t: unexpected result granted=%0d status=%0d",
                     $time, got.granted_word, got.status);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (got.granted_word !== want.granted_word) begin
            $display("%0t: granted_word expected %0d actual %0d",
                     $time, want.granted_word, got.granted_word);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;

   heap_ledger ledger;
   int gap_pct = 0;
   int idle_cycles = 0;
   localparam int StallLimit = 200000;

   first_fit_heap_allocator_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Results are sampled at the edge that ends their single valid cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid) ledger.check_answer(rsp_data);
   end

   // The watchdog restarts whenever either channel completes a transfer.
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("first_fit_heap_allocator_top verification failed");
            $finish;
         end
      end
   end

   // Presents one request, holds it until accepted, then notes it. The start
   // line stays high afterwards, so the next call or drain decides its level.
   task automatic send_request(req_type r);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         req_data <= r ^ req_type'($urandom);
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.note_request(r);
   endtask

   task automatic alloc_bytes(int unsigned nbytes);
      req_type r;
      r = '0;
      r.kind = 1'b0;
      r.request_bytes = nbytes[BytesW-1:0];
      r.release_word = AddrW'($urandom);
      r.release_present = 1'($urandom);
      send_request(r);
   endtask

   task automatic free_word(int unsigned w, bit present);
      req_type r;
      r = '0;
      r.kind = 1'b1;
      r.request_bytes = BytesW'($urandom);
      r.release_word = w[AddrW-1:0];
      r.release_present = present;
      send_request(r);
   endtask

   // Mostly frees of live chunks and modest allocations, with some noise.
   task automatic random_request();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40 && ledger.used_at.size() > 0)
         free_word(ledger.used_at[$urandom_range(ledger.used_at.size() - 1)], 1'b1);
      else if (pick < 45) free_word($urandom, 1'($urandom));
      else if (pick < 50) alloc_bytes($urandom_range((1 << BytesW) - 1));
      else if (pick < 55) alloc_bytes($urandom_range(8));
      else alloc_bytes($urandom_range(40000));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (ledger.owed.size() > 0) @(posedge clock);
   endtask

   initial begin
      ledger = new();
      ledger.clear();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: zero size, rounding edges, exact fit, no fit, null and
      // unknown frees, freeing twice, and coalescing of neighbors.
      alloc_bytes(0);
      alloc_bytes(1);
      alloc_bytes(8);
      alloc_bytes(9);
      alloc_bytes((1 << BytesW) - 1);
      alloc_bytes(524288);
      free_word(0, 1'b0);
      free_word(16'hFFFF, 1'b1);
      free_word(1, 1'b1);
      free_word(1, 1'b1);
      free_word(0, 1'b1);
      alloc_bytes(16);
      alloc_bytes(200000);
      alloc_bytes(200000);
      alloc_bytes(200000);
      free_word(ledger.used_at[ledger.used_at.size() - 1], 1'b1);
      alloc_bytes(((HeapWords - 4) * WordBytes));
      free_word(16'hFFFF, 1'b0);
      // Hold off until the allocator has answered everything outstanding.
      drain();
      while (ledger.used_at.size() > 0) free_word(ledger.used_at[0], 1'b1);
      alloc_bytes(HeapWords * WordBytes);
      free_word(0, 1'b1);

      // Random part in three idling phases.
      gap_pct = 35;
      repeat (40) random_request();
      gap_pct = 61;
      repeat (40) random_request();
      gap_pct = 0;
      repeat (40) random_request();

      drain();
      repeat (50) @(posedge clock);
      if (ledger.errors == 0 && ledger.owed.size() == 0) begin
         $display("first_fit_heap_allocator_top verification clean");
      end else begin
         $display("first_fit_heap_allocator_top verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
